@@ hdl/integer_to_ascii_radix_macros.svh @@
// Assertion macros for the integer-to-ASCII converter.
// Depends on clk and rst_n in the including module.
`ifndef INTEGER_TO_ASCII_RADIX_MACROS_SVH
`define INTEGER_TO_ASCII_RADIX_MACROS_SVH
`ifndef NO_ASSERTIONS
`define I2A_ASSERT_IMPLY(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("integer_to_ascii_radix: same-cycle check failed");
`define I2A_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("integer_to_ascii_radix: next-cycle check failed");
`else
`define I2A_ASSERT_IMPLY(label, pre, post)
`define I2A_ASSERT_NEXT(label, pre, post)
`endif
`endif

@@ hdl/i2a_pkg.sv @@
// Package for the integer-to-ASCII converter: format codes, microcode
// opcodes and conditions, control word type and the microcode ROM.
// No dependencies.
`default_nettype none

package i2a_pkg;

    localparam int LEN_W = 7;

    typedef logic [1:0] fmt_t;
    localparam fmt_t FMT_HEX = 2'd0;
    localparam fmt_t FMT_DEC = 2'd1;
    localparam fmt_t FMT_BIN = 2'd2;
    localparam fmt_t FMT_BAD = 2'd3;

    typedef logic [2:0] step_t;
    localparam step_t STEP_IDLE  = 3'd0;
    localparam step_t STEP_CHECK = 3'd1;
    localparam step_t STEP_CONV  = 3'd2;
    localparam step_t STEP_TOP   = 3'd3;
    localparam step_t STEP_SCAN  = 3'd4;
    localparam step_t STEP_PFX   = 3'd5;
    localparam step_t STEP_ERR   = 3'd6;
    localparam step_t STEP_EMIT  = 3'd7;

    typedef logic [2:0] op_t;
    localparam op_t OP_IDLE  = 3'd0;
    localparam op_t OP_CHECK = 3'd1;
    localparam op_t OP_CONV  = 3'd2;
    localparam op_t OP_TOP   = 3'd3;
    localparam op_t OP_SCAN  = 3'd4;
    localparam op_t OP_PFX   = 3'd5;
    localparam op_t OP_ERR   = 3'd6;
    localparam op_t OP_EMIT  = 3'd7;

    typedef logic [2:0] cond_t;
    localparam cond_t COND_NONE      = 3'd0;
    localparam cond_t COND_ALWAYS    = 3'd1;
    localparam cond_t COND_NO_INPUT  = 3'd2;
    localparam cond_t COND_FMT_BAD   = 3'd3;
    localparam cond_t COND_CONV_MORE = 3'd4;
    localparam cond_t COND_SCAN_MORE = 3'd5;
    localparam cond_t COND_EMIT_MORE = 3'd6;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_t;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [7:0] CHAR_X    = 8'h78;
    localparam logic [7:0] CHAR_B    = 8'h62;

    // Fall-through past the last step wraps to idle.
    function automatic ctrl_t ucode(input step_t s);
        ctrl_t w;
        unique case (s)
            STEP_IDLE:  w = '{op: OP_IDLE,  cond: COND_NO_INPUT,  target: STEP_IDLE};
            STEP_CHECK: w = '{op: OP_CHECK, cond: COND_FMT_BAD,   target: STEP_ERR};
            STEP_CONV:  w = '{op: OP_CONV,  cond: COND_CONV_MORE, target: STEP_CONV};
            STEP_TOP:   w = '{op: OP_TOP,   cond: COND_NONE,      target: STEP_IDLE};
            STEP_SCAN:  w = '{op: OP_SCAN,  cond: COND_SCAN_MORE, target: STEP_SCAN};
            STEP_PFX:   w = '{op: OP_PFX,   cond: COND_ALWAYS,    target: STEP_EMIT};
            STEP_ERR:   w = '{op: OP_ERR,   cond: COND_ALWAYS,    target: STEP_IDLE};
            STEP_EMIT:  w = '{op: OP_EMIT,  cond: COND_EMIT_MORE, target: STEP_EMIT};
            default:    w = '{op: OP_IDLE,  cond: COND_NONE,      target: STEP_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d <= 4'd9)
            c = CHAR_ZERO + {4'd0, d};
        else
            c = CHAR_A + {4'd0, d} - 8'd10;
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hdl/integer_to_ascii_radix.sv @@
// Integer-to-ASCII converter (hex with 0x, decimal, binary with 0b), up to two chars per transaction.
// Microcoded sequencer over a digit shift register; uses i2a_pkg and the macros header.
// Steps: check, then ceil(VALUE_WIDTH/4) shift-add-3 conversion steps for decimal (one otherwise),
// then leading zero digits skipped one per cycle, then the prefix, then the digit pairs.
// An error format goes from the check step to the error step and back to idle.
// rst_n clears the step counter and the output valid flag asynchronously.
`default_nettype none

`include "integer_to_ascii_radix_macros.svh"

module integer_to_ascii_radix
    import i2a_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [63:0]      value,
    input  wire logic [1:0]       format,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [7:0]            first_char,
    output logic [7:0]            second_char,
    output logic                  second_valid,
    output logic                  last,
    output logic                  error,
    output logic [LEN_W-1:0]      total_length
);

    localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
    localparam int HEX_W      = 4 * HEX_DIGITS;
    localparam int BCD_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int WORK_W     = (HEX_W > BCD_W) ? HEX_W : BCD_W;
    localparam int ALIGN      = WORK_W - HEX_W;
    localparam int CNT_W      = $clog2(HEX_W + 1);

    function automatic logic [BCD_W-1:0] dabble4(input logic [BCD_W-1:0] bcd_in,
                                                input logic [3:0] bits);
        logic [BCD_W-1:0] acc;
        acc = bcd_in;
        for (int s = 0; s < 4; s++)
        begin
            for (int d = 0; d < BCD_DIGITS; d++)
            begin
                if (acc[4*d +: 4] >= 4'd5)
                    acc[4*d +: 4] = acc[4*d +: 4] + 4'd3;
            end
            acc = {acc[BCD_W-2:0], bits[3-s]};
        end
        return acc;
    endfunction

    step_t              step_reg, step_next;
    fmt_t               fmt_reg, fmt_next;
    logic [HEX_W-1:0]   src_reg, src_next;
    logic [WORK_W-1:0]  work_reg, work_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [LEN_W-1:0]   len_reg, len_next;

    logic               out_valid_reg, out_valid_next;
    logic [7:0]         first_reg, first_next;
    logic [7:0]         second_reg, second_next;
    logic               sv_reg, sv_next;
    logic               last_reg, last_next;
    logic               err_reg, err_next;
    logic [LEN_W-1:0]   tlen_reg, tlen_next;

    ctrl_t              ctrl;
    logic               in_fire;
    logic               is_bin;
    logic               has_pfx;
    logic [3:0]         dig0, dig1;
    logic               out_free;
    logic               wants_out;
    logic               hold;
    logic               cond_true;
    logic               conv_more, scan_more, emit_more;

    assign ctrl     = ucode(step_reg);
    assign in_ready = (step_reg == STEP_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign is_bin   = (fmt_reg == FMT_BIN);
    assign has_pfx  = (fmt_reg == FMT_HEX) || (fmt_reg == FMT_BIN);

    assign dig0 = is_bin ? {3'd0, work_reg[WORK_W-1]} : work_reg[WORK_W-1 -: 4];
    assign dig1 = is_bin ? {3'd0, work_reg[WORK_W-2]} : work_reg[WORK_W-5 -: 4];

    assign conv_more = (fmt_reg == FMT_DEC) && (cnt_reg != CNT_W'(1));
    assign scan_more = (dig0 == 4'd0) && (cnt_reg != CNT_W'(1));
    assign emit_more = (cnt_reg > CNT_W'(2));

    assign out_free  = !out_valid_reg || out_ready;
    assign wants_out = (ctrl.op == OP_EMIT) || (ctrl.op == OP_ERR)
                    || ((ctrl.op == OP_PFX) && has_pfx);
    assign hold      = wants_out && !out_free;

    always_comb
    begin
        unique case (ctrl.cond)
            COND_NONE:      cond_true = 1'b0;
            COND_ALWAYS:    cond_true = 1'b1;
            COND_NO_INPUT:  cond_true = !in_fire;
            COND_FMT_BAD:   cond_true = (fmt_reg == FMT_BAD);
            COND_CONV_MORE: cond_true = conv_more;
            COND_SCAN_MORE: cond_true = scan_more;
            COND_EMIT_MORE: cond_true = emit_more;
            default:        cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        step_next      = step_reg;
        fmt_next       = fmt_reg;
        src_next       = src_reg;
        work_next      = work_reg;
        cnt_next       = cnt_reg;
        len_next       = len_reg;
        out_valid_next = out_valid_reg && !out_ready;
        first_next     = first_reg;
        second_next    = second_reg;
        sv_next        = sv_reg;
        last_next      = last_reg;
        err_next       = err_reg;
        tlen_next      = tlen_reg;

        if (!hold)
        begin
            step_next = cond_true ? ctrl.target : step_reg + 3'd1;
            unique case (ctrl.op)
                OP_IDLE:
                begin
                    if (in_fire)
                    begin
                        fmt_next = format;
                        src_next = HEX_W'(value[VALUE_WIDTH-1:0]);
                        work_next = (format == FMT_DEC) ? '0
                                  : (WORK_W'(value[VALUE_WIDTH-1:0]) << ALIGN);
                        cnt_next = CNT_W'(HEX_DIGITS);
                    end
                end
                OP_CHECK:
                begin
                end
                OP_CONV:
                begin
                    if (fmt_reg == FMT_DEC)
                    begin
                        work_next[WORK_W-1 -: BCD_W] =
                            dabble4(work_reg[WORK_W-1 -: BCD_W], src_reg[HEX_W-1 -: 4]);
                        src_next = src_reg << 4;
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                end
                OP_TOP:
                begin
                    unique case (fmt_reg)
                        FMT_HEX: cnt_next = CNT_W'(HEX_DIGITS);
                        FMT_DEC: cnt_next = CNT_W'(BCD_DIGITS);
                        FMT_BIN: cnt_next = CNT_W'(HEX_W);
                        default: cnt_next = CNT_W'(1);
                    endcase
                end
                OP_SCAN:
                begin
                    if (scan_more)
                    begin
                        work_next = is_bin ? (work_reg << 1) : (work_reg << 4);
                        cnt_next  = cnt_reg - CNT_W'(1);
                    end
                end
                OP_PFX:
                begin
                    len_next = LEN_W'(cnt_reg) + (has_pfx ? LEN_W'(2) : LEN_W'(0));
                    if (has_pfx)
                    begin
                        out_valid_next = 1'b1;
                        first_next     = CHAR_ZERO;
                        second_next    = is_bin ? CHAR_B : CHAR_X;
                        sv_next        = 1'b1;
                        last_next      = 1'b0;
                        err_next       = 1'b0;
                        tlen_next      = '0;
                    end
                end
                OP_ERR:
                begin
                    out_valid_next = 1'b1;
                    first_next     = 8'd0;
                    second_next    = 8'd0;
                    sv_next        = 1'b0;
                    last_next      = 1'b1;
                    err_next       = 1'b1;
                    tlen_next      = '0;
                end
                OP_EMIT:
                begin
                    out_valid_next = 1'b1;
                    first_next     = digit_char(dig0);
                    second_next    = (cnt_reg >= CNT_W'(2)) ? digit_char(dig1) : 8'd0;
                    sv_next        = (cnt_reg >= CNT_W'(2));
                    last_next      = !emit_more;
                    err_next       = 1'b0;
                    tlen_next      = emit_more ? LEN_W'(0) : len_reg;
                    work_next      = is_bin ? (work_reg << 2) : (work_reg << 8);
                    cnt_next       = emit_more ? (cnt_reg - CNT_W'(2)) : cnt_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fmt_reg    <= fmt_next;
        src_reg    <= src_next;
        work_reg   <= work_next;
        cnt_reg    <= cnt_next;
        len_reg    <= len_next;
        first_reg  <= first_next;
        second_reg <= second_next;
        sv_reg     <= sv_next;
        last_reg   <= last_next;
        err_reg    <= err_next;
        tlen_reg   <= tlen_next;
    end

    assign out_valid    = out_valid_reg;
    assign first_char   = first_reg;
    assign second_char  = second_reg;
    assign second_valid = sv_reg;
    assign last         = last_reg;
    assign error        = err_reg;
    assign total_length = tlen_reg;

    `I2A_ASSERT_NEXT(a_accept_to_check, in_valid && in_ready, step_reg == STEP_CHECK)
    `I2A_ASSERT_IMPLY(a_error_is_last, out_valid_reg && err_reg, last_reg && tlen_reg == '0)
    `I2A_ASSERT_IMPLY(a_midpair_full, out_valid_reg && !last_reg, sv_reg && tlen_reg == '0)
    `I2A_ASSERT_IMPLY(a_scan_count, step_reg == STEP_SCAN || step_reg == STEP_EMIT,
                      cnt_reg != '0)

endmodule

`default_nettype wire

@@ test/tb.sv @@
// Regression bench for integer_to_ascii_radix: directed corners, then random numbers under
// several idling mixes, each character pair checked against a text predictor in the bench.
// Depends on i2a_pkg and the integer_to_ascii_radix RTL.
module tb;
    import i2a_pkg::*;

    localparam int VALUE_BITS = 64;
    localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VALUE_BITS);
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 100;
    localparam int REPORT_MAX = 10;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_X = 8'h78;
    localparam logic [7:0] ASCII_B = 8'h62;

    typedef struct {
        logic [7:0]       first_char;
        logic [7:0]       second_char;
        logic             second_valid;
        logic             last;
        logic             error;
        logic [LEN_W-1:0] total_length;
    } char_pair_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [63:0]      value = '0;
    logic [1:0]       format = FMT_HEX;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [7:0]       first_char;
    logic [7:0]       second_char;
    logic             second_valid;
    logic             last;
    logic             error;
    logic [LEN_W-1:0] total_length;

    char_pair_t pending_pairs[$];
    int send_idle_pct = 0;
    int stall_pct = 0;
    int mismatch_count = 0;
    int numbers_sent = 0;
    int bad_formats_sent = 0;
    int pairs_seen = 0;
    int quiet_cycles = 0;

    integer_to_ascii_radix #(.VALUE_WIDTH(VALUE_BITS)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .value(value),
        .format(format),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .first_char(first_char),
        .second_char(second_char),
        .second_valid(second_valid),
        .last(last),
        .error(error),
        .total_length(total_length)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] digit_ascii(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10)
            c = ASCII_ZERO + 8'(d);
        else
            c = ASCII_UPPER_A + 8'(d) - 8'd10;
        return c;
    endfunction

    function automatic void predict_text(input logic [63:0] raw, input logic [1:0] fmt);
        logic [63:0] v;
        logic [3:0]  d;
        logic [7:0]  text[$];
        logic [7:0]  digits[$];
        char_pair_t  p;
        int          n;
        v = raw & VALUE_MASK;
        p = '{default: '0};
        if (fmt == FMT_BAD)
        begin
            p.last = 1'b1;
            p.error = 1'b1;
            pending_pairs.push_back(p);
            return;
        end
        if (fmt == FMT_HEX)
        begin
            text.push_back(ASCII_ZERO);
            text.push_back(ASCII_X);
        end
        else if (fmt == FMT_BIN)
        begin
            text.push_back(ASCII_ZERO);
            text.push_back(ASCII_B);
        end
        do
        begin
            if (fmt == FMT_HEX)
            begin
                d = v[3:0];
                v = v >> 4;
            end
            else if (fmt == FMT_BIN)
            begin
                d = {3'd0, v[0]};
                v = v >> 1;
            end
            else
            begin
                d = 4'(v % 64'd10);
                v = v / 64'd10;
            end
            digits.push_front(digit_ascii(d));
        end
        while (v != 0);
        foreach (digits[k])
            text.push_back(digits[k]);
        n = text.size();
        for (int i = 0; i < n; i += 2)
        begin
            p.first_char = text[i];
            p.second_valid = (i + 1 < n);
            p.second_char = p.second_valid ? text[i + 1] : 8'd0;
            p.last = (i + 2 >= n);
            p.error = 1'b0;
            p.total_length = p.last ? LEN_W'(n) : '0;
            pending_pairs.push_back(p);
        end
    endfunction

    task automatic report_mismatch(input string what, input char_pair_t want,
                                   input char_pair_t got);
        if (mismatch_count < REPORT_MAX)
            $display("mismatch (%s): expected %h %h v%0b l%0b e%0b len%0d, got %h %h v%0b l%0b e%0b len%0d",
                     what, want.first_char, want.second_char, want.second_valid, want.last,
                     want.error, want.total_length, got.first_char, got.second_char,
                     got.second_valid, got.last, got.error, got.total_length);
        mismatch_count++;
    endtask

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin : pair_checker
        char_pair_t want;
        char_pair_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{first_char, second_char, second_valid, last, error, total_length};
            pairs_seen++;
            if (pending_pairs.size() == 0)
            begin
                want = '{default: '0};
                report_mismatch("unexpected transaction", want, got);
            end
            else
            begin
                want = pending_pairs.pop_front();
                if (got.first_char !== want.first_char)
                    report_mismatch("first_char", want, got);
                else if (got.second_char !== want.second_char)
                    report_mismatch("second_char", want, got);
                else if (got.second_valid !== want.second_valid)
                    report_mismatch("second_valid", want, got);
                else if (got.last !== want.last)
                    report_mismatch("last", want, got);
                else if (got.error !== want.error)
                    report_mismatch("error", want, got);
                else if (got.total_length !== want.total_length)
                    report_mismatch("total_length", want, got);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("integer_to_ascii_radix regression: fail");
                $finish;
            end
        end
    end

    task automatic send_number(input logic [63:0] v, input logic [1:0] fmt);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value <= v;
        format <= fmt;
        do
            @(posedge clk);
        while (!in_ready);
        predict_text(v, fmt);
        numbers_sent++;
        if (fmt == FMT_BAD)
            bad_formats_sent++;
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_pairs.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_burst(input int count);
        logic [63:0] v;
        logic [1:0]  fmt;
        for (int i = 0; i < count; i++)
        begin
            v = {$urandom, $urandom} >> $urandom_range(63, 0);
            if ($urandom_range(9) == 0)
                v = '0;
            fmt = $urandom_range(9) == 0 ? FMT_BAD : 2'($urandom_range(2));
            send_number(v, fmt);
        end
    endtask

    task automatic test_directed_corners();
        send_number(64'd0, FMT_HEX);
        send_number(64'd0, FMT_DEC);
        send_number(64'd0, FMT_BIN);
        send_number({64{1'b1}}, FMT_HEX);
        send_number({64{1'b1}}, FMT_DEC);
        send_number({64{1'b1}}, FMT_BIN);
        send_number(64'd1, FMT_HEX);
        send_number(64'd1, FMT_DEC);
        send_number(64'd1, FMT_BIN);
        send_number(64'hFEDC_BA98_7654_3210, FMT_HEX);
        send_number(64'h0123_4567_89AB_CDEF, FMT_HEX);
        send_number(64'd9, FMT_DEC);
        send_number(64'd10, FMT_DEC);
        send_number(64'd10, FMT_HEX);
        send_number(64'd15, FMT_HEX);
        send_number(64'h8000_0000_0000_0000, FMT_BIN);
        send_number(64'h8000_0000_0000_0000, FMT_DEC);
        send_number(64'd9999999999999999999, FMT_DEC);
        send_number(64'd10000000000000000000, FMT_DEC);
        send_number({64{1'b1}}, FMT_BAD);
        send_number(64'd0, FMT_BAD);
        send_number(64'hAAAA_AAAA_AAAA_AAAA, FMT_BIN);
        send_number(64'h5555_5555_5555_5555, FMT_BIN);
    endtask

    task automatic test_streaming();
        send_idle_pct = 0;
        stall_pct = 0;
        send_random_burst(20);
    endtask

    task automatic test_sender_gaps();
        send_idle_pct = 71;
        stall_pct = 0;
        send_random_burst(20);
    endtask

    task automatic test_receiver_backpressure();
        send_idle_pct = 0;
        stall_pct = 71;
        send_random_burst(20);
    endtask

    task automatic test_mixed_idling();
        send_idle_pct = 13;
        stall_pct = 13;
        send_random_burst(20);
    endtask

    task automatic test_drain_pause();
        send_idle_pct = 0;
        stall_pct = 30;
        send_random_burst(5);
        wait_for_drain();
        send_random_burst(5);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_corners();
        test_streaming();
        test_sender_gaps();
        test_receiver_backpressure();
        test_mixed_idling();
        test_drain_pause();
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_pairs.size() != 0)
        begin
            $display("%0d expected pairs never arrived", pending_pairs.size());
            mismatch_count++;
        end
        $display("converted %0d numbers (%0d with an unknown format) into %0d pairs",
                 numbers_sent, bad_formats_sent, pairs_seen);
        $display("idling mixes: none, sender gaps, receiver stalls, both, drain pause; %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0)
            $display("integer_to_ascii_radix regression: pass");
        else
            $display("integer_to_ascii_radix regression: fail");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+hdl
hdl/i2a_pkg.sv
hdl/integer_to_ascii_radix.sv
test/tb.sv
